@@ rtl/core/apbm_pkg.sv @@
`default_nettype none

package apbm_pkg;

    // field widths
    localparam int COEF_W = 32;
    localparam int POS_W  = 16;
    localparam int SIZE_W = 15;
    localparam int OUT_W  = 32;
    localparam int DIM_W  = 31;
    localparam int FRAC_W = 16;

    // datapath widths: 32x16 products, exact sums, integer part after the shift
    localparam int PROD_W = COEF_W + POS_W;
    localparam int ACC_W  = PROD_W + 4;
    localparam int FLR_W  = ACC_W - FRAC_W;

    // APB map: register i at byte address 4*i
    localparam int ADDR_W = 5;
    localparam int IDX_W  = 3;

    localparam logic [IDX_W-1:0] REG_COEF_XX = 3'd0;
    localparam logic [IDX_W-1:0] REG_COEF_XY = 3'd1;
    localparam logic [IDX_W-1:0] REG_COEF_YX = 3'd2;
    localparam logic [IDX_W-1:0] REG_COEF_YY = 3'd3;
    localparam logic [IDX_W-1:0] REG_SHIFT_X = 3'd4;
    localparam logic [IDX_W-1:0] REG_SHIFT_Y = 3'd5;

    localparam logic [COEF_W-1:0] COEF_ONE  = 32'h0001_0000;
    localparam logic [COEF_W-1:0] COEF_ZERO = 32'h0000_0000;

    // 0.5 for round-to-nearest, and 1 - 2^-16 for ceiling
    localparam logic signed [ACC_W-1:0] HALF_Q   = ACC_W'(32768);
    localparam logic signed [ACC_W-1:0] CEIL_ADD = ACC_W'(65535);

    typedef enum logic {
        CMD_POINT = 1'b0,
        CMD_RECT  = 1'b1
    } cmd_t;

    typedef struct packed {
        logic signed [COEF_W-1:0] xx;
        logic signed [COEF_W-1:0] xy;
        logic signed [COEF_W-1:0] yx;
        logic signed [COEF_W-1:0] yy;
        logic signed [COEF_W-1:0] tx;
        logic signed [COEF_W-1:0] ty;
    } coef_set_t;

    // per-stage load enables of the datapath pipe
    typedef struct packed {
        logic s1;
        logic s2;
        logic s3;
    } pipe_en_t;

endpackage

`default_nettype wire

@@ rtl/core/apbm_regs.sv @@
`default_nettype none

module apbm_regs
    import apbm_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [ADDR_W-1:0] paddr,
    input  wire logic [31:0]       pwdata,
    output logic      [31:0]       prdata,
    output logic                   pready,
    output coef_set_t              coef
);

    logic [COEF_W-1:0] coef_xx_reg, coef_xx_next;
    logic [COEF_W-1:0] coef_xy_reg, coef_xy_next;
    logic [COEF_W-1:0] coef_yx_reg, coef_yx_next;
    logic [COEF_W-1:0] coef_yy_reg, coef_yy_next;
    logic [COEF_W-1:0] shift_x_reg, shift_x_next;
    logic [COEF_W-1:0] shift_y_reg, shift_y_next;
    logic              wr_en;
    logic [IDX_W-1:0]  idx;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;
    assign idx    = paddr[ADDR_W-1:2];

    always_comb
    begin
        coef_xx_next = coef_xx_reg;
        coef_xy_next = coef_xy_reg;
        coef_yx_next = coef_yx_reg;
        coef_yy_next = coef_yy_reg;
        shift_x_next = shift_x_reg;
        shift_y_next = shift_y_reg;
        if (wr_en)
        begin
            unique case (idx)
                REG_COEF_XX: coef_xx_next = pwdata;
                REG_COEF_XY: coef_xy_next = pwdata;
                REG_COEF_YX: coef_yx_next = pwdata;
                REG_COEF_YY: coef_yy_next = pwdata;
                REG_SHIFT_X: shift_x_next = pwdata;
                REG_SHIFT_Y: shift_y_next = pwdata;
                default:     ; // unmapped: dropped
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            coef_xx_reg <= COEF_ONE;
            coef_xy_reg <= COEF_ZERO;
            coef_yx_reg <= COEF_ZERO;
            coef_yy_reg <= COEF_ONE;
            shift_x_reg <= COEF_ZERO;
            shift_y_reg <= COEF_ZERO;
        end
        else
        begin
            coef_xx_reg <= coef_xx_next;
            coef_xy_reg <= coef_xy_next;
            coef_yx_reg <= coef_yx_next;
            coef_yy_reg <= coef_yy_next;
            shift_x_reg <= shift_x_next;
            shift_y_reg <= shift_y_next;
        end
    end

    always_comb
    begin
        unique case (idx)
            REG_COEF_XX: prdata = coef_xx_reg;
            REG_COEF_XY: prdata = coef_xy_reg;
            REG_COEF_YX: prdata = coef_yx_reg;
            REG_COEF_YY: prdata = coef_yy_reg;
            REG_SHIFT_X: prdata = shift_x_reg;
            REG_SHIFT_Y: prdata = shift_y_reg;
            default:     prdata = 32'h0;
        endcase
    end

    assign coef.xx = $signed(coef_xx_reg);
    assign coef.xy = $signed(coef_xy_reg);
    assign coef.yx = $signed(coef_yx_reg);
    assign coef.yy = $signed(coef_yy_reg);
    assign coef.tx = $signed(shift_x_reg);
    assign coef.ty = $signed(shift_y_reg);

endmodule

`default_nettype wire

@@ rtl/core/apbm_row.sv @@
`default_nettype none

// One output axis: v = a*x + b*y + t. The box corners only add a*w and/or b*h
// to the base corner, so min/max come from the signs of those two terms.
module apbm_row
    import apbm_pkg::*;
(
    input  wire logic                     clk,
    input  wire pipe_en_t                 en,
    input  wire logic                     cmd_s2,
    input  wire logic signed [COEF_W-1:0] coef_a,
    input  wire logic signed [COEF_W-1:0] coef_b,
    input  wire logic signed [COEF_W-1:0] shift,
    input  wire logic signed [POS_W-1:0]  pos_x,
    input  wire logic signed [POS_W-1:0]  pos_y,
    input  wire logic [SIZE_W-1:0]        size_w,
    input  wire logic [SIZE_W-1:0]        size_h,
    output logic signed [ACC_W-1:0]       lo,
    output logic signed [ACC_W-1:0]       hi
);

    logic signed [PROD_W-1:0] p_ax_reg, p_ax_next;
    logic signed [PROD_W-1:0] p_by_reg, p_by_next;
    logic signed [PROD_W-1:0] p_aw_reg, p_aw_next;
    logic signed [PROD_W-1:0] p_bh_reg, p_bh_next;
    logic signed [COEF_W-1:0] t1_reg;

    logic signed [ACC_W-1:0]  base_reg, base_next;
    logic signed [ACC_W-1:0]  lo_off_reg, lo_off_next;
    logic signed [ACC_W-1:0]  hi_off_reg, hi_off_next;

    logic signed [ACC_W-1:0]  lo_reg, lo_next;
    logic signed [ACC_W-1:0]  hi_reg, hi_next;

    logic signed [ACC_W-1:0]  aw_ext, bh_ext;
    logic signed [POS_W-1:0]  w_s, h_s;

    assign w_s = $signed({1'b0, size_w});
    assign h_s = $signed({1'b0, size_h});

    // stage 1: four 32x16 products
    assign p_ax_next = PROD_W'(coef_a) * PROD_W'(pos_x);
    assign p_by_next = PROD_W'(coef_b) * PROD_W'(pos_y);
    assign p_aw_next = PROD_W'(coef_a) * PROD_W'(w_s);
    assign p_bh_next = PROD_W'(coef_b) * PROD_W'(h_s);

    always_ff @(posedge clk)
    begin
        if (en.s1)
        begin
            p_ax_reg <= p_ax_next;
            p_by_reg <= p_by_next;
            p_aw_reg <= p_aw_next;
            p_bh_reg <= p_bh_next;
            t1_reg   <= shift;
        end
    end

    // stage 2: base corner and the negative / positive extents
    assign aw_ext = ACC_W'(p_aw_reg);
    assign bh_ext = ACC_W'(p_bh_reg);

    always_comb
    begin
        base_next   = ACC_W'(p_ax_reg) + ACC_W'(p_by_reg) + ACC_W'(t1_reg);
        lo_off_next = (aw_ext[ACC_W-1] ? aw_ext : '0) + (bh_ext[ACC_W-1] ? bh_ext : '0);
        hi_off_next = (aw_ext[ACC_W-1] ? '0 : aw_ext) + (bh_ext[ACC_W-1] ? '0 : bh_ext);
    end

    always_ff @(posedge clk)
    begin
        if (en.s2)
        begin
            base_reg   <= base_next;
            lo_off_reg <= lo_off_next;
            hi_off_reg <= hi_off_next;
        end
    end

    // stage 3: lo is the rounded point or the box minimum, hi is max + ceil bias
    always_comb
    begin
        lo_next = base_reg + ((cmd_s2 == CMD_RECT) ? lo_off_reg : HALF_Q);
        hi_next = base_reg + hi_off_reg + CEIL_ADD;
    end

    always_ff @(posedge clk)
    begin
        if (en.s3)
        begin
            lo_reg <= lo_next;
            hi_reg <= hi_next;
        end
    end

    assign lo = lo_reg;
    assign hi = hi_reg;

endmodule

`default_nettype wire

@@ rtl/core/apbm_fin.sv @@
`default_nettype none

// Integer part, box size and saturation for both axes.
module apbm_fin
    import apbm_pkg::*;
(
    input  wire logic                    cmd,
    input  wire logic signed [ACC_W-1:0] lo_x,
    input  wire logic signed [ACC_W-1:0] hi_x,
    input  wire logic signed [ACC_W-1:0] lo_y,
    input  wire logic signed [ACC_W-1:0] hi_y,
    output logic signed [OUT_W-1:0]      out_x,
    output logic signed [OUT_W-1:0]      out_y,
    output logic [DIM_W-1:0]             out_w,
    output logic [DIM_W-1:0]             out_h,
    output logic                         overflow
);

    logic signed [FLR_W-1:0] flr_x, flr_y, cel_x, cel_y;
    logic signed [FLR_W:0]   dif_x, dif_y;
    logic                    ovf_x, ovf_y, ovf_w, ovf_h;

    // arithmetic shift right by the fraction width is the floor
    assign flr_x = lo_x[ACC_W-1:FRAC_W];
    assign flr_y = lo_y[ACC_W-1:FRAC_W];
    assign cel_x = hi_x[ACC_W-1:FRAC_W];
    assign cel_y = hi_y[ACC_W-1:FRAC_W];

    // max >= min, so the size is never negative
    assign dif_x = (FLR_W+1)'(cel_x) - (FLR_W+1)'(flr_x);
    assign dif_y = (FLR_W+1)'(cel_y) - (FLR_W+1)'(flr_y);

    always_comb
    begin
        ovf_x = !((&flr_x[FLR_W-1:OUT_W-1]) || !(|flr_x[FLR_W-1:OUT_W-1]));
        ovf_y = !((&flr_y[FLR_W-1:OUT_W-1]) || !(|flr_y[FLR_W-1:OUT_W-1]));
        ovf_w = |dif_x[FLR_W:DIM_W];
        ovf_h = |dif_y[FLR_W:DIM_W];

        if (ovf_x)
            out_x = flr_x[FLR_W-1] ? {1'b1, {(OUT_W-1){1'b0}}} : {1'b0, {(OUT_W-1){1'b1}}};
        else
            out_x = flr_x[OUT_W-1:0];

        if (ovf_y)
            out_y = flr_y[FLR_W-1] ? {1'b1, {(OUT_W-1){1'b0}}} : {1'b0, {(OUT_W-1){1'b1}}};
        else
            out_y = flr_y[OUT_W-1:0];

        if (cmd == CMD_RECT)
        begin
            out_w    = ovf_w ? {DIM_W{1'b1}} : dif_x[DIM_W-1:0];
            out_h    = ovf_h ? {DIM_W{1'b1}} : dif_y[DIM_W-1:0];
            overflow = ovf_x || ovf_y || ovf_w || ovf_h;
        end
        else
        begin
            out_w    = '0;
            out_h    = '0;
            overflow = ovf_x || ovf_y;
        end
    end

endmodule

`default_nettype wire

@@ rtl/core/affine_point_and_box_map_top.sv @@
// Affine point / bounding-box mapper.
// Input channel (in_valid/in_ready) takes one word per cycle unless stalled; cmd
// selects point (x, y rounded half-up) or rectangle (floor of min, ceil-based size).
// Output channel (out_valid/out_ready) returns exactly one word per input word,
// in order; saturated fields raise overflow.
// Coefficients come from the APB port (6 x 32-bit Q16.16, byte address 4*i);
// they may only be rewritten while the pipe is empty. pready is tied high.
// Path: the input reg loads at the input accept edge, then multiply, partial sums,
// min/max and the result reg follow in order. Throughput: 1 word per cycle while
// out_ready keeps up, set by the fully pipelined datapath (8 multipliers, 32x16,
// one pass per word).
// Stall: each stage has its own valid and loads when empty or draining, so a
// held result only backs up the pipe gradually; in_ready drops once all five
// stages are full.
// Reset (rst_n, async, low) empties the pipe and loads the identity transform.
`default_nettype none

module affine_point_and_box_map_top
    import apbm_pkg::*;
(
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    // APB config
    input  wire logic                     psel,
    input  wire logic                     penable,
    input  wire logic                     pwrite,
    input  wire logic [ADDR_W-1:0]        paddr,
    input  wire logic [31:0]              pwdata,
    output logic      [31:0]              prdata,
    output logic                          pready,
    // input words
    input  wire logic                     in_valid,
    output logic                          in_ready,
    input  wire logic                     cmd,
    input  wire logic signed [POS_W-1:0]  pos_x,
    input  wire logic signed [POS_W-1:0]  pos_y,
    input  wire logic [SIZE_W-1:0]        size_w,
    input  wire logic [SIZE_W-1:0]        size_h,
    // result words
    output logic                          out_valid,
    input  wire logic                     out_ready,
    output logic signed [OUT_W-1:0]       out_x,
    output logic signed [OUT_W-1:0]       out_y,
    output logic [DIM_W-1:0]              out_w,
    output logic [DIM_W-1:0]              out_h,
    output logic                          overflow
);

    coef_set_t coef;

    // stage valids; stage 0 is the input register, stage 4 the result register
    logic v0_reg, v1_reg, v2_reg, v3_reg, v4_reg;
    logic rdy1, rdy2, rdy3, rdy4;
    pipe_en_t en;

    // cmd rides along with the data
    logic cmd0_reg, cmd1_reg, cmd2_reg, cmd3_reg;

    // input register
    logic signed [POS_W-1:0] pos_x0_reg, pos_y0_reg;
    logic [SIZE_W-1:0]       size_w0_reg, size_h0_reg;

    logic signed [ACC_W-1:0] lo_x, hi_x, lo_y, hi_y;

    logic signed [OUT_W-1:0] res_x, res_y;
    logic [DIM_W-1:0]        res_w, res_h;
    logic                    res_ovf;

    logic signed [OUT_W-1:0] out_x_reg, out_y_reg;
    logic [DIM_W-1:0]        out_w_reg, out_h_reg;
    logic                    ovf_reg;

    apbm_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .coef    (coef)
    );

    // ready chain: a stage can load when it is empty or its word moves on
    assign rdy4     = !v4_reg || out_ready;
    assign rdy3     = !v3_reg || rdy4;
    assign rdy2     = !v2_reg || rdy3;
    assign rdy1     = !v1_reg || rdy2;
    assign in_ready = !v0_reg || rdy1;

    // datapath loads only when a real word moves in
    assign en.s1 = rdy1 && v0_reg;
    assign en.s2 = rdy2 && v1_reg;
    assign en.s3 = rdy3 && v2_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v0_reg <= 1'b0;
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else
        begin
            if (in_ready)
                v0_reg <= in_valid;
            if (rdy1)
                v1_reg <= v0_reg;
            if (rdy2)
                v2_reg <= v1_reg;
            if (rdy3)
                v3_reg <= v2_reg;
            if (rdy4)
                v4_reg <= v3_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            cmd0_reg    <= cmd;
            pos_x0_reg  <= pos_x;
            pos_y0_reg  <= pos_y;
            size_w0_reg <= size_w;
            size_h0_reg <= size_h;
        end
        if (en.s1)
            cmd1_reg <= cmd0_reg;
        if (en.s2)
            cmd2_reg <= cmd1_reg;
        if (en.s3)
            cmd3_reg <= cmd2_reg;
    end

    apbm_row u_row_x (
        .clk    (clk),
        .en     (en),
        .cmd_s2 (cmd2_reg),
        .coef_a (coef.xx),
        .coef_b (coef.xy),
        .shift  (coef.tx),
        .pos_x  (pos_x0_reg),
        .pos_y  (pos_y0_reg),
        .size_w (size_w0_reg),
        .size_h (size_h0_reg),
        .lo     (lo_x),
        .hi     (hi_x)
    );

    apbm_row u_row_y (
        .clk    (clk),
        .en     (en),
        .cmd_s2 (cmd2_reg),
        .coef_a (coef.yx),
        .coef_b (coef.yy),
        .shift  (coef.ty),
        .pos_x  (pos_x0_reg),
        .pos_y  (pos_y0_reg),
        .size_w (size_w0_reg),
        .size_h (size_h0_reg),
        .lo     (lo_y),
        .hi     (hi_y)
    );

    apbm_fin u_fin (
        .cmd      (cmd3_reg),
        .lo_x     (lo_x),
        .hi_x     (hi_x),
        .lo_y     (lo_y),
        .hi_y     (hi_y),
        .out_x    (res_x),
        .out_y    (res_y),
        .out_w    (res_w),
        .out_h    (res_h),
        .overflow (res_ovf)
    );

    // result register
    always_ff @(posedge clk)
    begin
        if (rdy4 && v3_reg)
        begin
            out_x_reg <= res_x;
            out_y_reg <= res_y;
            out_w_reg <= res_w;
            out_h_reg <= res_h;
            ovf_reg   <= res_ovf;
        end
    end

    assign out_valid = v4_reg;
    assign out_x     = out_x_reg;
    assign out_y     = out_y_reg;
    assign out_w     = out_w_reg;
    assign out_h     = out_h_reg;
    assign overflow  = ovf_reg;

`ifndef SYNTHESIS
    // an empty result register never blocks the input side
    a_no_block: assert property (@(posedge clk) disable iff (!rst_n)
        !v4_reg |-> in_ready)
        else $error("in_ready low with empty result register");

    // an accepted word lands in the input register
    a_accept_lands: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> v0_reg)
        else $error("accepted word lost at input register");

    // a word in the last datapath stage is held while the output stalls
    a_hold_s3: assert property (@(posedge clk) disable iff (!rst_n)
        (v3_reg && !rdy4) |=> (v3_reg && $stable(cmd3_reg)))
        else $error("stage 3 word dropped during stall");

    // a word only leaves stage 3 into the result register
    a_s3_to_out: assert property (@(posedge clk) disable iff (!rst_n)
        (v3_reg && rdy4) |=> v4_reg)
        else $error("stage 3 word not moved to result register");
`endif

endmodule

`default_nettype wire

@@ bench/affine_point_and_box_map_top_tb.sv @@
`timescale 1ns / 1ps

module affine_point_and_box_map_top_tb
    import apbm_pkg::*;
();

    // Timing: 10 ns clock; RESET_CYCLES sets how long reset is held.
    localparam int HALF_PERIOD  = 5;
    localparam int RESET_CYCLES = 7;

    // The pipe is 5 stages deep, so DRAIN_CYCLES of quiet time means it is empty.
    localparam int DRAIN_CYCLES = 10;

    // Slowest legal run is roughly 1450 words, each with the longest send gap, the
    // long receive stall and the pipe transit, plus the config phases. CYCLE_LIMIT
    // leaves a wide margin.
    localparam int CYCLE_LIMIT = 1_000_000;

    // Receiver hold-off long enough to fill all five stages and stall in_ready.
    localparam int LONG_HOLD = 80;

    // Random part: phases of fresh coefficients, each with a block of words.
    localparam int RAND_PHASES = 10;
    localparam int PHASE_WORDS = 143;

    // Register indexes past the last real register; writes there are dropped.
    localparam logic [IDX_W-1:0] SPARE_IDX_A = 3'd6;
    localparam logic [IDX_W-1:0] SPARE_IDX_B = 3'd7;

    // Q16.16 corner values.
    localparam logic [COEF_W-1:0] Q_MIN      = 32'h8000_0000;
    localparam logic [COEF_W-1:0] Q_MAX      = 32'h7FFF_FFFF;
    localparam logic [COEF_W-1:0] Q_HALF     = 32'h0000_8000;
    localparam logic [COEF_W-1:0] Q_NEG_HALF = 32'hFFFF_8000;
    localparam logic [COEF_W-1:0] Q_NEG_ONE  = 32'hFFFF_0000;

    localparam logic signed [POS_W-1:0] POS_MIN  = 16'sh8000;
    localparam logic signed [POS_W-1:0] POS_MAX  = 16'sh7FFF;
    localparam logic [SIZE_W-1:0]       SIZE_MAX = 15'h7FFF;
    localparam logic signed [OUT_W-1:0] OUT_MIN  = 32'sh8000_0000;
    localparam logic signed [OUT_W-1:0] OUT_MAX  = 32'sh7FFF_FFFF;

    localparam longint S32_LO = -64'sd2147483648;
    localparam longint S32_HI = 64'sd2147483647;
    localparam longint HALF_UNIT = 64'sd32768;

    typedef struct packed {
        logic signed [OUT_W-1:0] x;
        logic signed [OUT_W-1:0] y;
        logic [DIM_W-1:0]        w;
        logic [DIM_W-1:0]        h;
        logic                    ovf;
    } map_result_t;

    typedef struct packed {
        cmd_t                    op;
        logic signed [POS_W-1:0] x;
        logic signed [POS_W-1:0] y;
        logic [SIZE_W-1:0]       w;
        logic [SIZE_W-1:0]       h;
    } in_word_t;

    // One directed row: which coefficient set, the word, and (when typed is
    // set) the result written out by hand instead of taken from the predictor.
    typedef struct packed {
        logic [1:0]  cfg;
        in_word_t    word;
        logic        typed;
        map_result_t res;
    } dir_row_t;

    // Set 0 is the reset state (identity), never written.
    // Set 1 drives both rows to their signed extremes so points saturate.
    // Set 2 scales by +/-0.5 to land on rounding ties.
    // Set 3 is a 90-degree turn with a fractional translation.
    localparam coef_set_t DIR_COEFS [4] = '{
        '{COEF_ONE,  COEF_ZERO, COEF_ZERO, COEF_ONE,   COEF_ZERO,    COEF_ZERO},
        '{Q_MIN,     Q_MIN,     Q_MAX,     Q_MAX,      Q_MAX,        Q_MIN},
        '{Q_HALF,    COEF_ZERO, COEF_ZERO, Q_NEG_HALF, COEF_ZERO,    COEF_ZERO},
        '{COEF_ZERO, Q_NEG_ONE, COEF_ONE,  COEF_ZERO,  32'h0001_2345, 32'hFFFE_8000}
    };

    localparam int NUM_DIR = 22;
    localparam dir_row_t DIR_ROWS [NUM_DIR] = '{
        // identity: points pass through, sizes ignored in point mode
        '{2'd0, '{CMD_POINT, 16'sd0, 16'sd0, 15'd0, 15'd0}, 1'b1,
          '{32'sd0, 32'sd0, 31'd0, 31'd0, 1'b0}},
        '{2'd0, '{CMD_POINT, POS_MAX, POS_MIN, SIZE_MAX, SIZE_MAX}, 1'b1,
          '{32'sd32767, -32'sd32768, 31'd0, 31'd0, 1'b0}},
        '{2'd0, '{CMD_POINT, POS_MIN, POS_MAX, 15'h5555, 15'h2AAA}, 1'b1,
          '{-32'sd32768, 32'sd32767, 31'd0, 31'd0, 1'b0}},
        // identity rectangles, including the widest ones and empty ones
        '{2'd0, '{CMD_RECT, POS_MIN, POS_MIN, SIZE_MAX, SIZE_MAX}, 1'b1,
          '{-32'sd32768, -32'sd32768, 31'd32767, 31'd32767, 1'b0}},
        '{2'd0, '{CMD_RECT, POS_MAX, POS_MAX, SIZE_MAX, SIZE_MAX}, 1'b1,
          '{32'sd32767, 32'sd32767, 31'd32767, 31'd32767, 1'b0}},
        '{2'd0, '{CMD_RECT, 16'sd100, -16'sd5, 15'd0, 15'd0}, 1'b1,
          '{32'sd100, -32'sd5, 31'd0, 31'd0, 1'b0}},
        '{2'd0, '{CMD_RECT, -16'sd1, 16'sd2, 15'd0, 15'd7}, 1'b1,
          '{-32'sd1, 32'sd2, 31'd0, 31'd7, 1'b0}},
        // extreme coefficients: both point outputs clamp, then no clamp at origin
        '{2'd1, '{CMD_POINT, POS_MIN, POS_MIN, 15'd0, 15'd0}, 1'b1,
          '{OUT_MAX, OUT_MIN, 31'd0, 31'd0, 1'b1}},
        '{2'd1, '{CMD_POINT, 16'sd0, 16'sd0, SIZE_MAX, 15'd0}, 1'b1,
          '{32'sd32768, -32'sd32768, 31'd0, 31'd0, 1'b0}},
        '{2'd1, '{CMD_RECT, POS_MIN, POS_MIN, SIZE_MAX, SIZE_MAX}, 1'b0, '0},
        '{2'd1, '{CMD_RECT, POS_MAX, POS_MAX, SIZE_MAX, SIZE_MAX}, 1'b0, '0},
        '{2'd1, '{CMD_RECT, POS_MIN, POS_MAX, SIZE_MAX, 15'd0}, 1'b0, '0},
        // half scales: ties round up, box edges floor/ceil
        '{2'd2, '{CMD_POINT, 16'sd1, 16'sd1, 15'd0, 15'd0}, 1'b1,
          '{32'sd1, 32'sd0, 31'd0, 31'd0, 1'b0}},
        '{2'd2, '{CMD_POINT, -16'sd1, -16'sd1, 15'd0, 15'd0}, 1'b1,
          '{32'sd0, 32'sd1, 31'd0, 31'd0, 1'b0}},
        '{2'd2, '{CMD_POINT, 16'sd3, -16'sd3, 15'd0, 15'd0}, 1'b1,
          '{32'sd2, 32'sd2, 31'd0, 31'd0, 1'b0}},
        '{2'd2, '{CMD_RECT, -16'sd3, -16'sd3, 15'd1, 15'd1}, 1'b1,
          '{-32'sd2, 32'sd1, 31'd1, 31'd1, 1'b0}},
        '{2'd2, '{CMD_RECT, 16'sd1, 16'sd1, 15'd1, 15'd0}, 1'b1,
          '{32'sd0, -32'sd1, 31'd1, 31'd1, 1'b0}},
        // rotation with fractional shift
        '{2'd3, '{CMD_POINT, 16'sd12, -16'sd34, 15'd9, 15'd9}, 1'b0, '0},
        '{2'd3, '{CMD_RECT, -16'sd100, 16'sd50, 15'd30, 15'd40}, 1'b0, '0},
        '{2'd3, '{CMD_RECT, POS_MAX, POS_MIN, SIZE_MAX, SIZE_MAX}, 1'b0, '0},
        '{2'd3, '{CMD_POINT, POS_MIN, POS_MAX, 15'd0, 15'd0}, 1'b0, '0},
        '{2'd3, '{CMD_RECT, 16'sd0, 16'sd0, 15'd0, 15'd0}, 1'b0, '0}
    };

    // Clock and reset
    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    // APB side
    logic              psel    = 1'b0;
    logic              penable = 1'b0;
    logic              pwrite  = 1'b0;
    logic [ADDR_W-1:0] paddr   = '0;
    logic [31:0]       pwdata  = '0;
    logic [31:0]       prdata;
    logic              pready;

    // Input word channel
    logic                    in_valid = 1'b0;
    logic                    in_ready;
    logic                    cmd      = 1'b0;
    logic signed [POS_W-1:0] pos_x    = '0;
    logic signed [POS_W-1:0] pos_y    = '0;
    logic [SIZE_W-1:0]       size_w   = '0;
    logic [SIZE_W-1:0]       size_h   = '0;

    // Result word channel
    logic                    out_valid;
    logic                    out_ready = 1'b0;
    logic signed [OUT_W-1:0] out_x;
    logic signed [OUT_W-1:0] out_y;
    logic [DIM_W-1:0]        out_w;
    logic [DIM_W-1:0]        out_h;
    logic                    overflow;

    // Hand-typed expectation riding along with the word being offered.
    logic        row_typed  = 1'b0;
    map_result_t row_result = '0;

    // Our copy of the coefficient registers, updated on every APB write.
    coef_set_t coefs = DIR_COEFS[0];

    map_result_t pending_maps [$];
    int          fail_count   = 0;
    int          cycle_count  = 0;
    logic        sender_burst = 1'b0;
    int          hold_reqs    = 0;

    affine_point_and_box_map_top dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .cmd       (cmd),
        .pos_x     (pos_x),
        .pos_y     (pos_y),
        .size_w    (size_w),
        .size_h    (size_h),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_x     (out_x),
        .out_y     (out_y),
        .out_w     (out_w),
        .out_h     (out_h),
        .overflow  (overflow)
    );

    always
    begin
        #(HALF_PERIOD) clk = 1'b1;
        #(HALF_PERIOD) clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    // Exact Q16.16 value of a*x + b*y + t; fits easily in 64 bits.
    function automatic longint affine_q(input logic signed [COEF_W-1:0] a,
                                        input logic signed [COEF_W-1:0] b,
                                        input logic signed [COEF_W-1:0] t,
                                        input longint x, input longint y);
        return longint'(a) * x + longint'(b) * y + longint'(t);
    endfunction

    function automatic longint clamp(input longint v, input longint lo,
                                     input longint hi, inout logic ovf);
        if (v > hi)
        begin
            ovf = 1'b1;
            return hi;
        end
        if (v < lo)
        begin
            ovf = 1'b1;
            return lo;
        end
        return v;
    endfunction

    function automatic map_result_t predict_map(input in_word_t wd);
        map_result_t r;
        longint      cx [4];
        longint      cy [4];
        longint      vx, vy, minx, maxx, miny, maxy, fx, fy;
        logic        ovf;
        ovf = 1'b0;
        r   = '0;
        if (wd.op == CMD_POINT)
        begin
            // round half up = floor(v + 0.5); >>> on a signed longint floors
            vx = affine_q(coefs.xx, coefs.xy, coefs.tx, longint'(wd.x), longint'(wd.y));
            vy = affine_q(coefs.yx, coefs.yy, coefs.ty, longint'(wd.x), longint'(wd.y));
            r.x = 32'(clamp((vx + HALF_UNIT) >>> FRAC_W, S32_LO, S32_HI, ovf));
            r.y = 32'(clamp((vy + HALF_UNIT) >>> FRAC_W, S32_LO, S32_HI, ovf));
        end
        else
        begin
            cx[0] = longint'(wd.x);
            cy[0] = longint'(wd.y);
            cx[1] = cx[0] + longint'(wd.w);
            cy[1] = cy[0];
            cx[2] = cx[1];
            cy[2] = cy[0] + longint'(wd.h);
            cx[3] = cx[0];
            cy[3] = cy[2];
            minx = affine_q(coefs.xx, coefs.xy, coefs.tx, cx[0], cy[0]);
            miny = affine_q(coefs.yx, coefs.yy, coefs.ty, cx[0], cy[0]);
            maxx = minx;
            maxy = miny;
            for (int i = 1; i < 4; i++)
            begin
                vx = affine_q(coefs.xx, coefs.xy, coefs.tx, cx[i], cy[i]);
                vy = affine_q(coefs.yx, coefs.yy, coefs.ty, cx[i], cy[i]);
                if (vx < minx) minx = vx;
                if (vx > maxx) maxx = vx;
                if (vy < miny) miny = vy;
                if (vy > maxy) maxy = vy;
            end
            fx = minx >>> FRAC_W;
            fy = miny >>> FRAC_W;
            // size from the unclamped floor and ceil; ceil(v) = -floor(-v)
            r.w = 31'(clamp(-((-maxx) >>> FRAC_W) - fx, 64'sd0, S32_HI, ovf));
            r.h = 31'(clamp(-((-maxy) >>> FRAC_W) - fy, 64'sd0, S32_HI, ovf));
            r.x = 32'(clamp(fx, S32_LO, S32_HI, ovf));
            r.y = 32'(clamp(fy, S32_LO, S32_HI, ovf));
        end
        r.ovf = ovf;
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Monitor: logs accepted words, checks accepted results, watchdog
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        map_result_t want;
        in_word_t    seen;
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("FAIL affine_point_and_box_map_top");
            $finish;
        end
        else if (rst_n)
        begin
            if (in_valid && in_ready)
            begin
                seen = '{cmd_t'(cmd), pos_x, pos_y, size_w, size_h};
                pending_maps.push_back(row_typed ? row_result : predict_map(seen));
            end
            if (out_valid && out_ready)
            begin
                if (pending_maps.size() == 0)
                begin
                    $error("result word with nothing expected: x=%0d y=%0d",
                           out_x, out_y);
                    fail_count++;
                end
                else
                begin
                    want = pending_maps.pop_front();
                    if (out_x !== want.x)
                    begin
                        $error("out_x: expected %0d, got %0d", want.x, out_x);
                        fail_count++;
                    end
                    if (out_y !== want.y)
                    begin
                        $error("out_y: expected %0d, got %0d", want.y, out_y);
                        fail_count++;
                    end
                    if (out_w !== want.w)
                    begin
                        $error("out_w: expected %0d, got %0d", want.w, out_w);
                        fail_count++;
                    end
                    if (out_h !== want.h)
                    begin
                        $error("out_h: expected %0d, got %0d", want.h, out_h);
                        fail_count++;
                    end
                    if (overflow !== want.ovf)
                    begin
                        $error("overflow: expected %0b, got %0b", want.ovf, overflow);
                        fail_count++;
                    end
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Random helpers
    // ------------------------------------------------------------------

    // Mostly back to back, some short gaps, a few long ones.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic signed [POS_W-1:0] pick_pos();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return POS_W'($urandom);
        if (r < 85) return POS_W'($urandom_range(0, 127) - 64);
        case ($urandom_range(0, 3))
            0:       return POS_MIN;
            1:       return POS_MAX;
            2:       return '0;
            default: return '1;
        endcase
    endfunction

    function automatic logic [SIZE_W-1:0] pick_size();
        int r;
        r = $urandom_range(0, 99);
        if (r < 45) return SIZE_W'($urandom);
        if (r < 80) return SIZE_W'($urandom_range(0, 16));
        if (r < 90) return '0;
        return SIZE_MAX;
    endfunction

    function automatic in_word_t draw_word();
        in_word_t wd;
        wd.op = $urandom_range(0, 1) ? CMD_RECT : CMD_POINT;
        wd.x  = pick_pos();
        wd.y  = pick_pos();
        wd.w  = pick_size();
        wd.h  = pick_size();
        return wd;
    endfunction

    // Four flavors of transform: raw random, everyday (+/-4.0 scale,
    // +/-1000 shift), corner values only, and scale/shear with wild shifts.
    function automatic coef_set_t draw_coefs(input int mode);
        logic [COEF_W-1:0] v [6];
        for (int i = 0; i < 6; i++)
        begin
            case (mode)
                0: v[i] = $urandom;
                1: v[i] = (i < 4) ? $urandom_range(0, 32'h8_0000) - 32'h4_0000
                                  : $urandom_range(0, 32'h7D0_0000) - 32'h3E8_0000;
                2:
                begin
                    case ($urandom_range(0, 5))
                        0:       v[i] = Q_MIN;
                        1:       v[i] = Q_MAX;
                        2:       v[i] = COEF_ZERO;
                        3:       v[i] = COEF_ONE;
                        4:       v[i] = Q_NEG_ONE;
                        default: v[i] = Q_HALF;
                    endcase
                end
                default:
                begin
                    if (i == 0 || i == 3)
                        v[i] = $urandom_range(0, 32'h4_0000) - 32'h2_0000;
                    else if (i < 4)
                        v[i] = $urandom_range(0, 32'h8000) - 32'h4000;
                    else
                        v[i] = $urandom;
                end
            endcase
        end
        return '{v[0], v[1], v[2], v[3], v[4], v[5]};
    endfunction

    // ------------------------------------------------------------------
    // Bus tasks (all entered and left at a falling edge)
    // ------------------------------------------------------------------

    // One APB transfer: setup, access, then one idle cycle on the bus so
    // the next transfer never re-drives psel in the same step.
    task automatic apb_cycle(input logic [IDX_W-1:0] idx, input logic [31:0] wdata,
                             input logic is_write, output logic [31:0] rdata);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= is_write;
        paddr   <= {idx, 2'b00};
        pwdata  <= wdata;
        @(negedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        rdata = prdata;
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(negedge clk);
    endtask

    // Write a register, mirror it in our copy and, if it is mapped, read it back.
    task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [31:0] value);
        logic [31:0] got;
        apb_cycle(idx, value, 1'b1, got);
        case (idx)
            REG_COEF_XX: coefs.xx = value;
            REG_COEF_XY: coefs.xy = value;
            REG_COEF_YX: coefs.yx = value;
            REG_COEF_YY: coefs.yy = value;
            REG_SHIFT_X: coefs.tx = value;
            REG_SHIFT_Y: coefs.ty = value;
            default: ;
        endcase
        if (idx <= REG_SHIFT_Y)
        begin
            apb_cycle(idx, '0, 1'b0, got);
            if (got !== value)
            begin
                $error("prdata[%0d]: expected %h, got %h", idx, value, got);
                fail_count++;
            end
        end
    endtask

    // Stop sending and let every outstanding result come back.
    task automatic wait_idle();
        in_valid <= 1'b0;
        while (pending_maps.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        @(negedge clk);
    endtask

    task automatic load_coefs(input coef_set_t s);
        wait_idle();
        write_reg(REG_COEF_XX, s.xx);
        write_reg(REG_COEF_XY, s.xy);
        write_reg(REG_COEF_YX, s.yx);
        write_reg(REG_COEF_YY, s.yy);
        write_reg(REG_SHIFT_X, s.tx);
        write_reg(REG_SHIFT_Y, s.ty);
        // junk to the unused indexes must leave everything alone
        write_reg(SPARE_IDX_A, $urandom);
        write_reg(SPARE_IDX_B, $urandom);
    endtask

    // Offer one word and hold it until accepted. in_valid is only touched
    // once per falling edge, so a word that follows directly keeps it high.
    task automatic send_word(input in_word_t wd, input logic typed,
                             input map_result_t res);
        int gap;
        gap = sender_burst ? 0 : pick_gap();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid   <= 1'b1;
        cmd        <= wd.op;
        pos_x      <= wd.x;
        pos_y      <= wd.y;
        size_w     <= wd.w;
        size_h     <= wd.h;
        row_typed  <= typed;
        row_result <= res;
        do @(posedge clk); while (!in_ready);
        @(negedge clk);
    endtask

    // ------------------------------------------------------------------
    // Receiver: out_ready pattern, one update per falling edge.
    // Alternates ready runs (some very long) with stalls; a hold request
    // from the stimulus forces one long stall so the pipe fills up.
    // ------------------------------------------------------------------
    initial
    begin
        int stall_left;
        int run_left;
        int holds_done;
        stall_left = 0;
        run_left   = 0;
        holds_done = 0;
        wait (rst_n);
        forever
        begin
            @(negedge clk);
            if (holds_done != hold_reqs)
            begin
                holds_done = hold_reqs;
                stall_left = LONG_HOLD;
            end
            else if (stall_left == 0 && run_left == 0)
            begin
                stall_left = pick_gap();
                run_left   = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 150)
                                                         : $urandom_range(1, 12);
            end
            if (stall_left > 0)
            begin
                out_ready <= 1'b0;
                stall_left--;
            end
            else
            begin
                out_ready <= 1'b1;
                if (run_left > 0) run_left--;
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------
    initial
    begin
        logic [1:0] cur_cfg;
        repeat (RESET_CYCLES) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed table. Set 0 rows run on the reset coefficients.
        cur_cfg = 2'd0;
        for (int i = 0; i < NUM_DIR; i++)
        begin
            if (DIR_ROWS[i].cfg != cur_cfg)
            begin
                cur_cfg = DIR_ROWS[i].cfg;
                load_coefs(DIR_COEFS[cur_cfg]);
            end
            send_word(DIR_ROWS[i].word, DIR_ROWS[i].typed, DIR_ROWS[i].res);
        end

        // Random phases, each on a fresh transform. Every third phase sends
        // without gaps; the first of those also asks for the long receiver
        // hold so in_ready has to drop while words keep coming.
        for (int phase = 0; phase < RAND_PHASES; phase++)
        begin
            load_coefs(draw_coefs(phase % 4));
            sender_burst = (phase % 3 == 1);
            if (phase == 1) hold_reqs++;
            for (int k = 0; k < PHASE_WORDS; k++)
            begin
                // sender pause until everything is back, once for sure
                if ((phase == 2 && k == PHASE_WORDS / 2) || $urandom_range(0, 199) == 0)
                    wait_idle();
                send_word(draw_word(), 1'b0, '0);
            end
        end

        wait_idle();
        if (fail_count == 0)
            $display("PASS affine_point_and_box_map_top");
        else
            $display("FAIL affine_point_and_box_map_top");
        $finish;
    end

endmodule
